@@ hw/rtl/gnss_binary_frame_parser_core_assert.svh @@
// ----------------------------------------------------------------------------
// GNSS frame parser assertion macros
// Clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef GNSS_BINARY_FRAME_PARSER_CORE_ASSERT_SVH
`define GNSS_BINARY_FRAME_PARSER_CORE_ASSERT_SVH

// Same-cycle implication
`define GBFP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define GBFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/gbfp_pkg.sv @@
// ----------------------------------------------------------------------------
// gbfp_pkg
// Types and constants shared by the GNSS binary frame parser modules.
// ----------------------------------------------------------------------------
package gbfp_pkg;

    // Largest payload the parser will count
    localparam int MAX_PAYLOAD = 128;
    localparam int PAY_CAP     = (MAX_PAYLOAD < 128) ? MAX_PAYLOAD : 128;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int TDATA_W    = 112;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MSG_CLASS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MSG_ID       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FIX_POS      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_FIX_CODE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_ONLY    = 3'd7;

    typedef enum logic [3:0] {
        PH_SYNC1   = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_ID      = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CK_A    = 4'd7,
        PH_CK_B    = 4'd8
    } phase_t;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] msg_class;
        logic [7:0] msg_id;
        logic [7:0] payload_bytes;
        logic [6:0] fix_type_position;
        logic [7:0] no_fix_code;
        logic [7:0] time_only_code;
    } cfg_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [6:0]  payload_index;
        logic        frame_end;
        logic        checksum_ok;
        logic        fix_valid;
        logic [7:0]  fix_type;
        logic [15:0] declared_length;
        logic [31:0] frame_count;
        logic [31:0] fix_count;
    } result_t;

endpackage

@@ hw/rtl/gbfp_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// gbfp_cfg_regs
// Configuration register file, write only, loaded with the frame defaults.
// ----------------------------------------------------------------------------
module gbfp_cfg_regs
    import gbfp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write into the addressed field
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_SYNC_FIRST:  cfg_next.sync_first        = cfg_data;
                CFG_SYNC_SECOND: cfg_next.sync_second       = cfg_data;
                CFG_MSG_CLASS:   cfg_next.msg_class         = cfg_data;
                CFG_MSG_ID:      cfg_next.msg_id            = cfg_data;
                CFG_PAYLOAD_LEN: cfg_next.payload_bytes     = cfg_data;
                CFG_FIX_POS:     cfg_next.fix_type_position = cfg_data[6:0];
                CFG_NO_FIX_CODE: cfg_next.no_fix_code       = cfg_data;
                CFG_TIME_ONLY:   cfg_next.time_only_code    = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_first        <= 8'd181;
            cfg_reg.sync_second       <= 8'd98;
            cfg_reg.msg_class         <= 8'd1;
            cfg_reg.msg_id            <= 8'd7;
            cfg_reg.payload_bytes     <= 8'd92;
            cfg_reg.fix_type_position <= 7'd20;
            cfg_reg.no_fix_code       <= 8'd0;
            cfg_reg.time_only_code    <= 8'd5;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/gbfp_parser.sv @@
// ----------------------------------------------------------------------------
// gbfp_parser
// Frame state machine, Fletcher-8 sums, fix capture and frame/fix counters.
// Advances by one byte on each accepted item and forms that byte's result.
// ----------------------------------------------------------------------------
module gbfp_parser
    import gbfp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       byte_accept,
    input  logic [7:0] rx_byte,
    output result_t    result
);

    phase_t      phase_reg, phase_next;
    logic [6:0]  pos_reg, pos_next;
    logic [7:0]  sum_lo_reg, sum_lo_next;
    logic [7:0]  sum_hi_reg, sum_hi_next;
    logic [7:0]  ck_a_reg, ck_a_next;
    logic [7:0]  len_lo_reg, len_lo_next;
    logic [15:0] len_word_reg, len_word_next;
    logic [7:0]  fix_reg, fix_next;
    logic [31:0] frames_reg, frames_next;
    logic [31:0] fixes_reg, fixes_next;

    logic [7:0]  eff_len;
    logic        last_payload;
    logic [7:0]  add_lo;
    logic [7:0]  add_hi;

    // Clamp the payload length to 1..cap
    always_comb begin
        if (cfg.payload_bytes == 8'd0) begin
            eff_len = 8'd1;
        end else if (cfg.payload_bytes > 8'(PAY_CAP)) begin
            eff_len = 8'(PAY_CAP);
        end else begin
            eff_len = cfg.payload_bytes;
        end
    end

    assign last_payload = ({1'b0, pos_reg} + 8'd1) >= eff_len;

    // Running Fletcher step on the current byte
    assign add_lo = sum_lo_reg + rx_byte;
    assign add_hi = sum_hi_reg + add_lo;

    // Next state and result for this byte
    always_comb begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        sum_lo_next   = sum_lo_reg;
        sum_hi_next   = sum_hi_reg;
        ck_a_next     = ck_a_reg;
        len_lo_next   = len_lo_reg;
        len_word_next = len_word_reg;
        fix_next      = fix_reg;
        frames_next   = frames_reg;
        fixes_next    = fixes_reg;

        result.payload_valid = 1'b0;
        result.payload_byte  = 8'd0;
        result.payload_index = 7'd0;
        result.frame_end     = 1'b0;
        result.checksum_ok   = 1'b0;
        result.fix_valid     = 1'b0;

        case (phase_reg)
            PH_SYNC1: begin
                if (rx_byte == cfg.sync_first) phase_next = PH_SYNC2;
            end
            PH_SYNC2: begin
                phase_next = (rx_byte == cfg.sync_second) ? PH_CLASS : PH_SYNC1;
            end
            PH_CLASS: begin
                if (rx_byte == cfg.msg_class) begin
                    // restart the sums on the class byte
                    sum_lo_next = rx_byte;
                    sum_hi_next = rx_byte;
                    phase_next  = PH_ID;
                end else begin
                    phase_next = PH_SYNC1;
                end
            end
            PH_ID: begin
                if (rx_byte == cfg.msg_id) begin
                    sum_lo_next = add_lo;
                    sum_hi_next = add_hi;
                    phase_next  = PH_LEN_LO;
                end else begin
                    phase_next = PH_SYNC1;
                end
            end
            PH_LEN_LO: begin
                len_lo_next = rx_byte;
                sum_lo_next = add_lo;
                sum_hi_next = add_hi;
                phase_next  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                len_word_next = {rx_byte, len_lo_reg};
                sum_lo_next   = add_lo;
                sum_hi_next   = add_hi;
                pos_next      = 7'd0;
                phase_next    = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                sum_lo_next          = add_lo;
                sum_hi_next          = add_hi;
                result.payload_valid = 1'b1;
                result.payload_byte  = rx_byte;
                result.payload_index = pos_reg;
                if (pos_reg == cfg.fix_type_position) fix_next = rx_byte;
                if (last_payload) begin
                    pos_next   = 7'd0;
                    phase_next = PH_CK_A;
                end else begin
                    pos_next = pos_reg + 7'd1;
                end
            end
            PH_CK_A: begin
                ck_a_next  = rx_byte;
                phase_next = PH_CK_B;
            end
            PH_CK_B: begin
                result.frame_end = 1'b1;
                if (ck_a_reg == sum_lo_reg && rx_byte == sum_hi_reg) begin
                    result.checksum_ok = 1'b1;
                    frames_next        = frames_reg + 32'd1;
                    if (fix_reg != cfg.no_fix_code && fix_reg != cfg.time_only_code) begin
                        result.fix_valid = 1'b1;
                        fixes_next       = fixes_reg + 32'd1;
                    end
                end
                phase_next = PH_SYNC1;
            end
            default: begin
                phase_next = PH_SYNC1;
            end
        endcase

        result.fix_type        = fix_next;
        result.declared_length = len_word_next;
        result.frame_count     = frames_next;
        result.fix_count       = fixes_next;
    end

    // Advance state only on an accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SYNC1;
            pos_reg      <= 7'd0;
            sum_lo_reg   <= 8'd0;
            sum_hi_reg   <= 8'd0;
            ck_a_reg     <= 8'd0;
            len_lo_reg   <= 8'd0;
            len_word_reg <= 16'd0;
            fix_reg      <= 8'd0;
            frames_reg   <= 32'd0;
            fixes_reg    <= 32'd0;
        end else if (byte_accept) begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            sum_lo_reg   <= sum_lo_next;
            sum_hi_reg   <= sum_hi_next;
            ck_a_reg     <= ck_a_next;
            len_lo_reg   <= len_lo_next;
            len_word_reg <= len_word_next;
            fix_reg      <= fix_next;
            frames_reg   <= frames_next;
            fixes_reg    <= fixes_next;
        end
    end

endmodule

@@ hw/rtl/gbfp_out_stage.sv @@
// ----------------------------------------------------------------------------
// gbfp_out_stage
// Result register between the parser and the master channel.
// Loads a new result whenever it is empty or its item is being taken.
// ----------------------------------------------------------------------------
module gbfp_out_stage
    import gbfp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_result,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign in_ready = !valid_reg || out_ready;

    // Hold the item until taken, refill in the same cycle
    always_comb begin
        valid_next = valid_reg;
        if (in_ready) valid_next = in_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) data_reg <= in_result;
    end

    assign out_valid  = valid_reg;
    assign out_result = data_reg;

endmodule

@@ hw/rtl/gnss_binary_frame_parser_core.sv @@
// ----------------------------------------------------------------------------
// gnss_binary_frame_parser_core
// Byte-stream frame parser with Fletcher-8 check, fix flag and counters.
//
//   channel | dir | tdata                 | tuser         | tlast
//   s_      | in  | rx_byte [7:0]         | -             | -
//   m_      | out | see m_tdata below     | payload_valid | frame_end
//   cfg_    | in  | 3-bit index, 8-bit data, write only
//
// One byte per cycle while the output is not stalled: each accepted item
// yields exactly one result item, registered in the next cycle, through a
// single result register. Throughput is set by that register: a new item is
// taken whenever the register is empty or its item is taken in the same cycle.
// m_tready low holds the result and s_tready low until it is taken.
// Reset clears the parser to the sync hunt, the counters to zero and
// loads the default configuration.
// ----------------------------------------------------------------------------
module gnss_binary_frame_parser_core
    import gbfp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // rx_byte [7:0]
    input  logic [7:0]            s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // payload_byte [7:0], payload_index [14:8], checksum_ok [15], fix_valid [16],
    // fix_type [24:17], declared_length [40:25], frame_count [72:41],
    // fix_count [104:73], zero [111:105]
    output logic [TDATA_W-1:0]    m_tdata,
    // payload_valid [0]
    output logic                  m_tuser,
    output logic                  m_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    result_t step_result;
    result_t out_result;
    logic    byte_accept;

    assign byte_accept = s_tvalid && s_tready;

    gbfp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gbfp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .byte_accept (byte_accept),
        .rx_byte     (s_tdata),
        .result      (step_result)
    );

    gbfp_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_result  (step_result),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    // Pack the result fields, payload_byte in the lowest bits
    assign m_tdata = {7'd0,
                      out_result.fix_count,
                      out_result.frame_count,
                      out_result.declared_length,
                      out_result.fix_type,
                      out_result.fix_valid,
                      out_result.checksum_ok,
                      out_result.payload_index,
                      out_result.payload_byte};
    assign m_tuser = out_result.payload_valid;
    assign m_tlast = out_result.frame_end;

endmodule

@@ hw/rtl/gbfp_checker.sv @@
// ----------------------------------------------------------------------------
// gbfp_checker
// Port-level checks of the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "gnss_binary_frame_parser_core_assert.svh"

module gbfp_checker
    import gbfp_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic [7:0]            s_tdata,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [TDATA_W-1:0]    m_tdata,
    input logic                  m_tuser,
    input logic                  m_tlast,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic                  cfg_we,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    // Stalled result stays offered and unchanged
    `GBFP_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `GBFP_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")

    // An empty result register never blocks the input
    `GBFP_ASSERT_NOW(a_ready_empty, !m_tvalid, s_tready, "input blocked with empty output")

    // A payload byte is never the frame end
    `GBFP_ASSERT_NOW(a_pay_not_end, m_tvalid && m_tuser, !m_tlast, "payload item marked frame end")

    // A valid fix only closes a frame with good checksum
    `GBFP_ASSERT_NOW(a_fix_good, m_tvalid && m_tdata[16], m_tlast && m_tdata[15], "fix without good frame")

endmodule

bind gnss_binary_frame_parser_core gbfp_checker u_gbfp_checker (.*);
